/* sv/source_text_lexer_assert.svh */
// Assertion macros shared by the source text lexer RTL.
// Needs only the including module's clock and reset nets.
`ifndef SOURCE_TEXT_LEXER_ASSERT_SVH
`define SOURCE_TEXT_LEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STLX_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("source_text_lexer: assertion failed");

// Next-cycle implication, checked outside reset.
`define STLX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("source_text_lexer: assertion failed");

`endif

/* sv/stlx_pkg.sv */
// Package for the source text lexer: widths, token codes, scan modes,
// result record type and small character and rounding helpers. No dependencies.
`default_nettype none
package stlx_pkg;

    localparam int LENGTH_BITS     = 12;
    localparam int LINE_BITS       = 20;
    localparam int COLUMN_BITS     = 16;
    localparam int FRACTION_DIGITS = 9;
    localparam int VALUE_BITS      = 31;
    localparam int FRAC_BITS       = 30;
    localparam int KEPT_BITS       = 4;
    localparam int TYPE_BITS       = 5;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [VALUE_BITS-1:0]  VAL_MAX  = '1;
    localparam logic [KEPT_BITS-1:0]   KEPT_MAX = KEPT_BITS'(FRACTION_DIGITS);

    // Token type codes.
    localparam logic [TYPE_BITS-1:0] TOK_UNKNOWN = 5'd0;
    localparam logic [TYPE_BITS-1:0] TOK_LPAREN  = 5'd1;
    localparam logic [TYPE_BITS-1:0] TOK_RPAREN  = 5'd2;
    localparam logic [TYPE_BITS-1:0] TOK_COLON   = 5'd3;
    localparam logic [TYPE_BITS-1:0] TOK_SEMI    = 5'd4;
    localparam logic [TYPE_BITS-1:0] TOK_STAR    = 5'd5;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACK  = 5'd6;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACK  = 5'd7;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACE  = 5'd8;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACE  = 5'd9;
    localparam logic [TYPE_BITS-1:0] TOK_EQUAL   = 5'd10;
    localparam logic [TYPE_BITS-1:0] TOK_COMMA   = 5'd11;
    localparam logic [TYPE_BITS-1:0] TOK_BAR     = 5'd12;
    localparam logic [TYPE_BITS-1:0] TOK_HASH    = 5'd13;
    localparam logic [TYPE_BITS-1:0] TOK_STRING  = 5'd14;
    localparam logic [TYPE_BITS-1:0] TOK_IDENT   = 5'd15;
    localparam logic [TYPE_BITS-1:0] TOK_NUMBER  = 5'd16;
    localparam logic [TYPE_BITS-1:0] TOK_SPACE   = 5'd17;
    localparam logic [TYPE_BITS-1:0] TOK_EOL     = 5'd18;
    localparam logic [TYPE_BITS-1:0] TOK_COMMENT = 5'd19;
    localparam logic [TYPE_BITS-1:0] TOK_END     = 5'd20;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_SPACE,
        MODE_EOL, MODE_SLASH, MODE_LCOMM, MODE_BCOMM, MODE_STRING
    } mode_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0]   token_type;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [LENGTH_BITS-1:0] text_length;
        logic [VALUE_BITS-1:0]  rounded_value;
        logic [VALUE_BITS-1:0]  whole_part;
        logic [FRAC_BITS-1:0]   fraction_digits;
        logic [KEPT_BITS-1:0]   fraction_count;
        logic                   last;
    } res_t;

    // Results of one step handed from the lexer to the result queue.
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == 8'd13) || (c == 8'd10);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        return ((a == 8'd13) && (b == 8'd10)) || ((a == 8'd10) && (b == 8'd13));
    endfunction

    // Punctuation code, or TOK_UNKNOWN when the byte is not punctuation.
    function automatic logic [TYPE_BITS-1:0] punct_code(input logic [7:0] c);
        logic [TYPE_BITS-1:0] t;
        case (c)
            8'h28:   t = TOK_LPAREN;
            8'h29:   t = TOK_RPAREN;
            8'h3A:   t = TOK_COLON;
            8'h3B:   t = TOK_SEMI;
            8'h2A:   t = TOK_STAR;
            8'h5B:   t = TOK_LBRACK;
            8'h5D:   t = TOK_RBRACK;
            8'h7B:   t = TOK_LBRACE;
            8'h7D:   t = TOK_RBRACE;
            8'h3D:   t = TOK_EQUAL;
            8'h2C:   t = TOK_COMMA;
            8'h7C:   t = TOK_BAR;
            8'h23:   t = TOK_HASH;
            default: t = TOK_UNKNOWN;
        endcase
        return t;
    endfunction

    // Half of one whole unit when k+1 fraction digits are kept: 5 * 10^k.
    function automatic logic [FRAC_BITS-1:0] half_step(input logic [KEPT_BITS-1:0] k);
        logic [FRAC_BITS-1:0] h;
        case (k)
            4'd0:    h = 30'd5;
            4'd1:    h = 30'd50;
            4'd2:    h = 30'd500;
            4'd3:    h = 30'd5000;
            4'd4:    h = 30'd50000;
            4'd5:    h = 30'd500000;
            4'd6:    h = 30'd5000000;
            4'd7:    h = 30'd50000000;
            default: h = 30'd500000000;
        endcase
        return h;
    endfunction

    // Build one result record; number fields only for numbers.
    function automatic res_t make_res(
        input logic [TYPE_BITS-1:0]   t,
        input logic [LINE_BITS-1:0]   ln,
        input logic [COLUMN_BITS-1:0] cl,
        input logic [LENGTH_BITS-1:0] len,
        input logic [VALUE_BITS-1:0]  wv,
        input logic [FRAC_BITS-1:0]   fv,
        input logic [KEPT_BITS-1:0]   fk
    );
        res_t r;
        logic up;
        r = '0;
        up = (fk != '0) && (fv >= half_step(fk - 1'b1));
        r.token_type   = t;
        r.start_line   = ln;
        r.start_column = cl;
        r.text_length  = len;
        if (t == TOK_NUMBER) begin
            r.rounded_value   = (up && (wv != VAL_MAX)) ? wv + 1'b1 : wv;
            r.whole_part      = wv;
            r.fraction_digits = fv;
            r.fraction_count  = fk;
        end
        return r;
    endfunction

    // Space, line end and comment tokens are shown only when enabled.
    function automatic logic shown(input logic [TYPE_BITS-1:0] t, input logic en);
        return en || !((t == TOK_SPACE) || (t == TOK_EOL) || (t == TOK_COMMENT));
    endfunction

endpackage
`default_nettype wire

/* sv/source_text_lexer.sv */
// Channel    | Dir | Handshake          | Payload
// s_         | in  | s_tvalid/s_tready  | s_tdata: char_code
// m_         | out | m_tvalid/m_tready  | m_tuser: token_type, m_tdata: number/position
// cfg_       | in  | cfg_valid/cfg_ready| cfg_data: emit_ignored
// One character per cycle while the queue has room: an item passes the input
// register and the lexer logic and lands in the two-entry result queue.
// Two tokens from one item fill the queue; the next item waits until the second is being popped.
// Reset (aresetn low, synchronous) returns line/column to one and mode to idle.
// A stalled output with a token queued blocks the next push, then s_tready drops.
// Depends on stlx_pkg, stlx_lexer, stlx_outq and source_text_lexer_assert.svh.
`default_nettype none
module source_text_lexer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_code
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [19:0] start_line, [35:20] start_column, [47:36] text_length,
    // [78:48] rounded_value, [109:79] whole_part, [139:110] fraction_digits,
    // [143:140] fraction_count
    output logic [143:0]      m_tdata,
    output logic [4:0]        m_tuser,   // [4:0] token_type
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data
);
    import stlx_pkg::*;

    logic       in_vld_reg;
    logic [7:0] char_reg;
    logic       emit_reg;
    logic       room;
    logic       fire;
    step_out_t  step_out;
    res_t       out_res;

    assign fire      = in_vld_reg && room;
    assign s_tready  = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            emit_reg <= cfg_data;
        end
    end

    stlx_lexer u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (fire),
        .char_code    (char_reg),
        .emit_ignored (emit_reg),
        .step_out     (step_out)
    );

    stlx_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .step_out  (step_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.token_type;
    assign m_tlast = out_res.last;
    assign m_tdata = {out_res.fraction_count, out_res.fraction_digits, out_res.whole_part,
                      out_res.rounded_value, out_res.text_length, out_res.start_column,
                      out_res.start_line};

`include "source_text_lexer_assert.svh"

    `STLX_ASSERT_NOW(a_hold_when_full, aclk, aresetn, in_vld_reg && !room, !s_tready)
    `STLX_ASSERT_NOW(a_end_is_last, aclk, aresetn, m_tvalid && (m_tuser == TOK_END), m_tlast)
    `STLX_ASSERT_NOW(a_plain_no_number, aclk, aresetn, m_tvalid && (m_tuser != TOK_NUMBER), m_tdata[143:48] == '0)

endmodule
`default_nettype wire

/* sv/stlx_lexer.sv */
// Lexer state registers and the single-pass next-state and token logic.
// Depends on stlx_pkg.
`default_nettype none
module stlx_lexer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic [7:0]         char_code,
    input  wire logic               emit_ignored,
    output stlx_pkg::step_out_t     step_out
);
    import stlx_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [VALUE_BITS-1:0]  whole_reg, whole_next;
    logic [FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [KEPT_BITS-1:0]   kept_reg, kept_next;
    logic                   esc_reg, esc_next;
    logic                   star_reg, star_next;

    logic                   fresh;
    logic                   ea, eb, va, vb;
    res_t                   ra, rb;
    logic [VALUE_BITS+3:0]  wide;
    logic [7:0]             c;
    logic [TYPE_BITS-1:0]   pc;

    assign c  = char_code;
    assign pc = punct_code(char_code);

    // One character: finish the open token, then maybe start another.
    always_comb begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        len_next   = len_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        kept_next  = kept_reg;
        esc_next   = esc_reg;
        star_next  = star_reg;
        fresh = 1'b1;
        ea = 1'b0;
        eb = 1'b0;
        ra = '0;
        rb = '0;
        wide = '0;

        case (mode_reg)
            MODE_IDENT: begin
                if (is_alpha(c) || is_digit(c) || (c == 8'h5F)) begin
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_IDENT, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_INT: begin
                if (is_digit(c)) begin
                    wide = {4'd0, whole_next} * 35'd10 + {27'd0, c - 8'h30};
                    whole_next = (wide > {4'd0, VAL_MAX}) ? VAL_MAX : wide[VALUE_BITS-1:0];
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else if (c == 8'h2E) begin
                    mode_next = MODE_FRAC;
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_NUMBER, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_FRAC: begin
                if (is_digit(c)) begin
                    if (kept_next < KEPT_MAX) begin
                        frac_next = FRAC_BITS'(frac_next * 30'd10) + {22'd0, c - 8'h30};
                        kept_next = kept_next + 1'b1;
                    end
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_NUMBER, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_SPACE: begin
                if (is_space(c)) begin
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_SPACE, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_EOL: begin
                if (is_pair(held_reg, c)) begin
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    mode_next = MODE_IDLE;
                    fresh = 1'b0;
                end
                ea = 1'b1;
                ra = make_res(TOK_EOL, tline_next, tcol_next, len_next,
                              whole_next, frac_next, kept_next);
                held_next = 8'd0;
            end
            MODE_SLASH: begin
                if (c == 8'h2F) begin
                    mode_next = MODE_LCOMM;
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else if (c == 8'h2A) begin
                    mode_next = MODE_BCOMM;
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    star_next = 1'b0;
                    held_next = 8'd0;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_UNKNOWN, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_LCOMM: begin
                if ((c != 8'd0) && !is_eol(c)) begin
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    fresh = 1'b0;
                end else begin
                    ea = 1'b1;
                    ra = make_res(TOK_COMMENT, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end
            end
            MODE_BCOMM: begin
                if (c == 8'd0) begin
                    ea = 1'b1;
                    ra = make_res(TOK_COMMENT, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end else begin
                    fresh = 1'b0;
                    if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    if (star_reg && (c == 8'h2F)) begin
                        if (col_next != COL_MAX) col_next = col_next + 1'b1;
                        ea = 1'b1;
                        ra = make_res(TOK_COMMENT, tline_next, tcol_next, len_next,
                                      whole_next, frac_next, kept_next);
                        mode_next = MODE_IDLE;
                        star_next = 1'b0;
                        held_next = 8'd0;
                    end else begin
                        star_next = (c == 8'h2A);
                        if (is_eol(c)) begin
                            if (is_pair(held_reg, c)) begin
                                held_next = 8'd0;
                            end else begin
                                if (line_next != LINE_MAX) line_next = line_next + 1'b1;
                                col_next  = COLUMN_BITS'(1);
                                held_next = c;
                            end
                        end else begin
                            held_next = 8'd0;
                            if (col_next != COL_MAX) col_next = col_next + 1'b1;
                        end
                    end
                end
            end
            MODE_STRING: begin
                if (c == 8'd0) begin
                    ea = 1'b1;
                    ra = make_res(TOK_STRING, tline_next, tcol_next, len_next,
                                  whole_next, frac_next, kept_next);
                end else begin
                    fresh = 1'b0;
                    if (col_next != COL_MAX) col_next = col_next + 1'b1;
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    end else if (c == 8'h22) begin
                        ea = 1'b1;
                        ra = make_res(TOK_STRING, tline_next, tcol_next, len_next,
                                      whole_next, frac_next, kept_next);
                        mode_next = MODE_IDLE;
                    end else begin
                        if (c == 8'h5C) esc_next = 1'b1;
                        if (len_next != LEN_MAX) len_next = len_next + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // The character opens a new token.
        if (fresh) begin
            tline_next = line_next;
            tcol_next  = col_next;
            len_next   = LENGTH_BITS'(1);
            whole_next = '0;
            frac_next  = '0;
            kept_next  = '0;
            esc_next   = 1'b0;
            star_next  = 1'b0;
            mode_next  = MODE_IDLE;
            if (c == 8'd0) begin
                eb = 1'b1;
                rb = make_res(TOK_END, tline_next, tcol_next, '0, '0, '0, '0);
                held_next  = 8'd0;
                line_next  = LINE_BITS'(1);
                col_next   = COLUMN_BITS'(1);
                tline_next = LINE_BITS'(1);
                tcol_next  = COLUMN_BITS'(1);
                len_next   = '0;
            end else begin
                if (col_next != COL_MAX) col_next = col_next + 1'b1;
                if (pc != TOK_UNKNOWN) begin
                    eb = 1'b1;
                    rb = make_res(pc, tline_next, tcol_next, len_next, '0, '0, '0);
                end else if (c == 8'h22) begin
                    len_next  = '0;
                    mode_next = MODE_STRING;
                end else if (is_space(c)) begin
                    mode_next = MODE_SPACE;
                end else if (is_eol(c)) begin
                    held_next = c;
                    if (line_next != LINE_MAX) line_next = line_next + 1'b1;
                    col_next  = COLUMN_BITS'(1);
                    mode_next = MODE_EOL;
                end else if (c == 8'h2F) begin
                    mode_next = MODE_SLASH;
                end else if (is_alpha(c)) begin
                    mode_next = MODE_IDENT;
                end else if (is_digit(c)) begin
                    whole_next = {23'd0, c - 8'h30};
                    mode_next  = MODE_INT;
                end else begin
                    eb = 1'b1;
                    rb = make_res(TOK_UNKNOWN, tline_next, tcol_next, len_next,
                                  '0, '0, '0);
                end
            end
        end
    end

    // Drop hidden tokens, pack the rest and mark the final one.
    always_comb begin
        va = ea && shown(ra.token_type, emit_ignored);
        vb = eb && shown(rb.token_type, emit_ignored);
        step_out.count = {1'b0, va} + {1'b0, vb};
        step_out.r0 = va ? ra : rb;
        step_out.r1 = rb;
        step_out.r0.last = !(va && vb);
        step_out.r1.last = 1'b1;
    end

    // State registers advance once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            held_reg  <= 8'd0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COLUMN_BITS'(1);
            tline_reg <= LINE_BITS'(1);
            tcol_reg  <= COLUMN_BITS'(1);
            len_reg   <= '0;
            whole_reg <= '0;
            frac_reg  <= '0;
            kept_reg  <= '0;
            esc_reg   <= 1'b0;
            star_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            len_reg   <= len_next;
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            kept_reg  <= kept_next;
            esc_reg   <= esc_next;
            star_reg  <= star_next;
        end
    end

endmodule
`default_nettype wire

/* sv/stlx_outq.sv */
// Two-entry result queue between the lexer step and the output channel.
// Depends on stlx_pkg.
`default_nettype none
module stlx_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire stlx_pkg::step_out_t step_out,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output stlx_pkg::res_t           out_res
);
    import stlx_pkg::*;

    res_t       q_reg [2];
    res_t       q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = q_reg[0];
    assign pop       = out_valid && out_ready;
    // Both entries are free after this cycle's pop.
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // Pop shifts the head; a push lands in an empty queue.
    always_comb begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 1'b1;
        end
        if (push) begin
            q_next[0] = step_out.r0;
            q_next[1] = step_out.r1;
            cnt_next  = step_out.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule
`default_nettype wire
